>>> hdl/bfsd3_pkg.sv
// ----------------------------------------------------------------------------
// bfsd3_pkg
// Shared types and constants for the distance-three breadth-first search
// block: payload structs, request and status codes, controller interface.
// ----------------------------------------------------------------------------
package bfsd3_pkg;

  localparam int MAX_VERTICES_DEF    = 32;
  localparam int TARGET_DISTANCE_DEF = 3;
  localparam int FIELD_LIMIT         = 32;
  localparam int VTX_W               = 5;
  localparam int CNT_W               = 6;

  localparam logic REQ_ADD_EDGE = 1'b0;
  localparam logic REQ_QUERY    = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_UNKNOWN = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
  } req_t;

  typedef struct packed {
    logic             status;
    logic             found;
    logic [VTX_W-1:0] vertex;
    logic             last;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic reject;
    logic edge_write;
    logic q_init;
    logic deq;
    logic enq;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic a_bad;
    logic b_bad;
    logic queue_ne;
    logic pend_any;
  } sts_t;

endpackage

>>> hdl/bfsd3_ctrl.sv
// ----------------------------------------------------------------------------
// bfsd3_ctrl
// Sequencer: decodes a request and, for a query, walks the search queue
// with at most one dequeue or one enqueue per cycle until the queue drains.
// ----------------------------------------------------------------------------
module bfsd3_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  bfsd3_pkg::sts_t sts,
  output bfsd3_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_DEQ,
    S_EXP
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.is_query) begin
          if (sts.a_bad || sts.b_bad) cmd.reject = 1'b1;
          else cmd.edge_write = 1'b1;
          state_next = S_IDLE;
        end else if (sts.a_bad) begin
          cmd.reject = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.q_init = 1'b1;
          state_next = S_DEQ;
        end
      end
      S_DEQ: begin
        if (sts.queue_ne) begin
          cmd.deq    = 1'b1;
          state_next = S_EXP;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EXP: begin
        if (sts.pend_any) cmd.enq = 1'b1;
        else state_next = S_DEQ;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/bfsd3_dp.sv
// ----------------------------------------------------------------------------
// bfsd3_dp
// Datapath: adjacency matrix, visited mask, search queue, neighbor
// picker, one-deep hit buffer for last marking, and the result register.
// ----------------------------------------------------------------------------
module bfsd3_dp #(
  parameter int MAX_VERTICES    = bfsd3_pkg::MAX_VERTICES_DEF,
  parameter int TARGET_DISTANCE = bfsd3_pkg::TARGET_DISTANCE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bfsd3_pkg::CNT_W-1:0] cfg_wdata,
  input  bfsd3_pkg::req_t             req,
  input  bfsd3_pkg::cmd_t             cmd,
  output bfsd3_pkg::sts_t             sts,
  output logic                        rsp_valid,
  output bfsd3_pkg::rsp_t             rsp
);

  localparam int NV = (MAX_VERTICES < bfsd3_pkg::FIELD_LIMIT) ?
                      MAX_VERTICES : bfsd3_pkg::FIELD_LIMIT;
  localparam int VW = $clog2(NV);
  localparam int CW = $clog2(NV + 1);
  localparam int DW = $clog2(TARGET_DISTANCE + 1);
  localparam int LW = bfsd3_pkg::CNT_W;

  logic [LW-1:0]     vertex_count;
  bfsd3_pkg::req_t   req_q;
  logic [NV-1:0]     adj [NV];
  logic [NV-1:0]     visited;
  logic [VW-1:0]     queue_v [NV];
  logic [DW-1:0]     queue_d [NV];
  logic [CW-1:0]     head;
  logic [CW-1:0]     tail;
  logic [NV-1:0]     pend;
  logic [DW-1:0]     cur_dist;
  logic [VW-1:0]     hit_v;
  logic              hit_valid;

  logic [LW-1:0]     lim;
  logic [NV-1:0]     valid_mask;
  logic [VW-1:0]     a_idx;
  logic [VW-1:0]     b_idx;
  logic [VW-1:0]     head_v;
  logic [DW-1:0]     head_d;
  logic [VW-1:0]     pick;

  assign lim = (vertex_count > LW'(NV)) ? LW'(NV) : vertex_count;

  always_comb begin
    for (int i = 0; i < NV; i++) begin
      valid_mask[i] = (LW'(i) < lim);
    end
  end

  always_comb begin
    pick = '0;
    for (int i = NV - 1; i >= 0; i--) begin
      if (pend[i]) pick = VW'(i);
    end
  end

  assign a_idx  = req_q.vertex_a[VW-1:0];
  assign b_idx  = req_q.vertex_b[VW-1:0];
  assign head_v = queue_v[head[VW-1:0]];
  assign head_d = queue_d[head[VW-1:0]];

  assign sts.is_query = (req_q.req_type == bfsd3_pkg::REQ_QUERY);
  assign sts.a_bad    = (LW'(req_q.vertex_a) >= lim);
  assign sts.b_bad    = (LW'(req_q.vertex_b) >= lim);
  assign sts.queue_ne = (head < tail);
  assign sts.pend_any = (|pend) && (LW'(tail) < lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NV; i++) begin
        adj[i] <= '0;
      end
    end else if (cmd.edge_write) begin
      adj[a_idx][b_idx] <= 1'b1;
      adj[b_idx][a_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_init) begin
      queue_v[0] <= a_idx;
      queue_d[0] <= '0;
    end else if (cmd.enq) begin
      queue_v[tail[VW-1:0]] <= pick;
      queue_d[tail[VW-1:0]] <= cur_dist + DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deq) begin
      if (head_d != DW'(TARGET_DISTANCE)) begin
        cur_dist <= head_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited   <= '0;
      head      <= '0;
      tail      <= '0;
      pend      <= '0;
      hit_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= cmd.reject | cmd.edge_write | cmd.finish |
                   (cmd.deq && (head_d == DW'(TARGET_DISTANCE)) && hit_valid);
      if (cmd.reject) begin
        rsp       <= '{status: bfsd3_pkg::STATUS_UNKNOWN, found: 1'b0,
                       vertex: '0, last: 1'b1};
      end
      if (cmd.edge_write) begin
        rsp       <= '{status: bfsd3_pkg::STATUS_OK, found: 1'b0,
                       vertex: '0, last: 1'b1};
      end
      if (cmd.q_init) begin
        visited        <= {{(NV-1){1'b0}}, 1'b1} << a_idx;
        head           <= '0;
        tail           <= CW'(1);
        pend           <= '0;
        hit_valid      <= 1'b0;
      end
      if (cmd.deq) begin
        head <= head + CW'(1);
        if (head_d == DW'(TARGET_DISTANCE)) begin
          pend      <= '0;
          hit_v     <= head_v;
          hit_valid <= 1'b1;
          if (hit_valid) begin
            rsp       <= '{status: bfsd3_pkg::STATUS_OK, found: 1'b1,
                           vertex: bfsd3_pkg::VTX_W'(hit_v), last: 1'b0};
          end
        end else begin
          pend <= adj[head_v] & valid_mask & ~visited;
        end
      end
      if (cmd.enq) begin
        tail          <= tail + CW'(1);
        visited[pick] <= 1'b1;
        pend[pick]    <= 1'b0;
      end
      if (cmd.finish) begin
        if (hit_valid) begin
          rsp <= '{status: bfsd3_pkg::STATUS_OK, found: 1'b1,
                   vertex: bfsd3_pkg::VTX_W'(hit_v), last: 1'b1};
        end else begin
          rsp <= '{status: bfsd3_pkg::STATUS_OK, found: 1'b0,
                   vertex: '0, last: 1'b1};
        end
      end
    end
  end

endmodule

>>> hdl/bfs_vertices_at_distance_three.sv
// ----------------------------------------------------------------------------
// bfs_vertices_at_distance_three
// Undirected graph store with a breadth-first query that reports every
// vertex at shortest distance TARGET_DISTANCE from a start vertex.
//
//   channel   signals                     transfer
//   request   start, busy, req            start && !busy
//   result    rsp_valid, rsp              rsp_valid (one cycle, no stall)
//   config    cfg_we, cfg_wdata           cfg_we
//
// An edge add or a rejected request: busy while the request is decoded,
// result in the cycle busy drops. A query dequeues and enqueues at most
// as many vertices as the vertex count; the queue walk does at most one
// dequeue or one enqueue per cycle. Results of a query appear as hits are
// found; the last one comes in the cycle busy drops.
// Synchronous reset clears the edge matrix and vertex_count at once.
// ----------------------------------------------------------------------------
module bfs_vertices_at_distance_three #(
  parameter int MAX_VERTICES    = bfsd3_pkg::MAX_VERTICES_DEF,
  parameter int TARGET_DISTANCE = bfsd3_pkg::TARGET_DISTANCE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  bfsd3_pkg::req_t             req,
  output logic                        rsp_valid,
  output bfsd3_pkg::rsp_t             rsp,
  input  logic                        cfg_we,
  input  logic [bfsd3_pkg::CNT_W-1:0] cfg_wdata
);

  bfsd3_pkg::cmd_t cmd;
  bfsd3_pkg::sts_t sts;

  bfsd3_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bfsd3_dp #(
    .MAX_VERTICES    (MAX_VERTICES),
    .TARGET_DISTANCE (TARGET_DISTANCE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

>>> hdl/bfsd3_checker.sv
// ----------------------------------------------------------------------------
// bfsd3_checker
// Port-level checks on request, busy and result sequencing.
// ----------------------------------------------------------------------------
module bfsd3_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            rsp_valid,
  input bfsd3_pkg::rsp_t rsp
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after request transfer");

  a_status_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == bfsd3_pkg::STATUS_UNKNOWN) |-> rsp.last && !rsp.found)
    else $error("unknown-vertex result not a single last result");

  a_notfound_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.last)
    else $error("result without vertex is not last");

  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> busy)
    else $error("non-last result while idle");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> rsp_valid && rsp.last)
    else $error("busy dropped without last result");

endmodule

bind bfs_vertices_at_distance_three bfsd3_checker u_bfsd3_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .rsp_valid (rsp_valid),
  .rsp       (rsp)
);
